// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clock, reset active high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define XB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define XB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/xbeu_pkg.sv =====
// ---------------------------------------------------------------------------
// xbeu_pkg
// Shared types and constants of the 8086 branch execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package xbeu_pkg;

   localparam int XB_STACK_WORDS = 1024;
   localparam int REQ_W          = 120;
   localparam int RSP_W          = 96;

   // opcodes
   localparam logic [7:0] OP_JCC_FIRST = 8'h60;
   localparam logic [7:0] OP_JCC_LAST  = 8'h7F;
   localparam logic [7:0] OP_CALL_FAR  = 8'h9A;
   localparam logic [7:0] OP_RET_IMM   = 8'hC2;
   localparam logic [7:0] OP_RET       = 8'hC3;
   localparam logic [7:0] OP_RETF_IMM  = 8'hCA;
   localparam logic [7:0] OP_RETF      = 8'hCB;
   localparam logic [7:0] OP_INT3      = 8'hCC;
   localparam logic [7:0] OP_INT       = 8'hCD;
   localparam logic [7:0] OP_INTO      = 8'hCE;
   localparam logic [7:0] OP_IRET      = 8'hCF;
   localparam logic [7:0] OP_LOOPNZ    = 8'hE0;
   localparam logic [7:0] OP_LOOPZ     = 8'hE1;
   localparam logic [7:0] OP_LOOP      = 8'hE2;
   localparam logic [7:0] OP_JCXZ      = 8'hE3;
   localparam logic [7:0] OP_CALL_NEAR = 8'hE8;
   localparam logic [7:0] OP_JMP_NEAR  = 8'hE9;
   localparam logic [7:0] OP_JMP_FAR   = 8'hEA;
   localparam logic [7:0] OP_JMP_SHORT = 8'hEB;
   localparam logic [7:0] OP_HLT       = 8'hF4;

   // flag bit positions
   localparam int FL_CF = 0;
   localparam int FL_PF = 2;
   localparam int FL_ZF = 6;
   localparam int FL_SF = 7;
   localparam int FL_OF = 11;

   localparam logic [7:0] VEC_BREAK    = 8'd3;
   localparam logic [7:0] VEC_OVERFLOW = 8'd4;

   // Jcc condition pairs, opcode bits [3:1]
   typedef enum logic [2:0] {
      CC_O, CC_B, CC_Z, CC_BE, CC_S, CC_P, CC_L, CC_LE
   } cc_type;

   // one access to the stack memory; sp is the byte address of the word
   typedef struct packed {
      logic        en;
      logic        we;
      logic [15:0] sp;
      logic [15:0] wdata;
   } stk_req_type;

endpackage

`default_nettype wire

// ===== src/x86_branch_execute_unit_top.sv =====
// ---------------------------------------------------------------------------
// x86_branch_execute_unit_top
// Executes one 8086 control-transfer instruction per request.
// ---------------------------------------------------------------------------
// Each request carries one jump, loop, call, return, interrupt or HLT opcode
// with the current IP, CS, SP, CX and FLAGS; the response gives the updated
// registers, halt, software interrupt request and vector, and a status bit
// (1 = opcode not handled, registers passed through). Pushes and pops go to
// an internal STACK_WORDS-word stack RAM with a single port, one access per
// cycle, so the request rate is set by stack traffic: while rsp_tready is
// high, one request per cycle for instructions with no or one stack access
// (jumps, Jcc, loops, near CALL/RET, INT, HLT); far CALL, RETF and IRET
// take no new request until all their stack accesses are done. Each response
// is registered and held until rsp_tready. Stack words never written since
// reset read as undefined.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module x86_branch_execute_unit_top import xbeu_pkg::*; #(
   parameter int STACK_WORDS = XB_STACK_WORDS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // opcode[7:0], imm_word[23:8], imm_segment[39:24], cur_ip[55:40],
   // cur_cs[71:56], cur_sp[87:72], cur_cx[103:88], cur_flags[119:104]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // new_ip[15:0], new_cs[31:16], new_sp[47:32], new_cx[63:48],
   // new_flags[79:64], halt_now[80], int_request[81], int_vector[89:82],
   // status[90], zero[95:91]
   output logic [RSP_W-1:0] rsp_tdata
);

   typedef struct packed {
      logic [7:0]  opcode;
      logic [15:0] imm_word;
      logic [15:0] imm_segment;
      logic [15:0] cur_ip;
      logic [15:0] cur_cs;
      logic [15:0] cur_sp;
      logic [15:0] cur_cx;
      logic [15:0] cur_flags;
   } item_type;

   item_type         req_item;
   item_type         work_ff;
   logic             busy_ff, busy_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [1:0]       work_n, req_n;
   logic [15:0]      pop0_ff, pop1_ff;
   logic [15:0]      stk_rdata;
   stk_req_type      stk_req;
   logic             req_accept, out_free, finishing, fin_go;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0] rsp_tdata_ff;

   logic [15:0] res_ip, res_cs, res_sp, res_cx, res_flags;
   logic        res_halt, res_irq, res_status;
   logic [7:0]  res_vec;
   logic [15:0] short_tgt, cx_dec, sp_pop;
   logic        sf_eq_of, jcc_take, zf;

   // number of stack accesses of an opcode
   function automatic logic [1:0] stack_ops(input logic [7:0] op);
      case (op) inside
         OP_CALL_NEAR, OP_RET, OP_RET_IMM: return 2'd1;
         OP_CALL_FAR, OP_RETF, OP_RETF_IMM: return 2'd2;
         OP_IRET:                           return 2'd3;
         default:                           return 2'd0;
      endcase
   endfunction

   function automatic logic is_push(input logic [7:0] op);
      return (op == OP_CALL_NEAR) || (op == OP_CALL_FAR);
   endfunction

   // access k of an item: pushes go downward from SP, pops upward
   function automatic stk_req_type stack_access(input item_type it, input logic [1:0] k);
      stk_req_type r;
      r.en = 1'b1;
      r.we = is_push(it.opcode);
      if (r.we) begin
         r.sp = it.cur_sp - 16'({k + 2'd1, 1'b0});
      end else begin
         r.sp = it.cur_sp + 16'({k, 1'b0});
      end
      r.wdata = (it.opcode == OP_CALL_FAR && k == 2'd0) ? it.cur_cs : it.cur_ip;
      return r;
   endfunction

   assign req_item = item_type'({req_tdata[7:0], req_tdata[23:8], req_tdata[39:24],
                                 req_tdata[55:40], req_tdata[71:56], req_tdata[87:72],
                                 req_tdata[103:88], req_tdata[119:104]});

   assign req_n      = stack_ops(req_item.opcode);
   assign work_n     = stack_ops(work_ff.opcode);
   assign finishing  = busy_ff && (cnt_ff == work_n);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign fin_go     = finishing && out_free;
   assign req_tready = !busy_ff || fin_go;
   assign req_accept = req_tvalid && req_tready;

   // first access issues in the accept cycle; while finishing, the port serves only a newly accepted request
   always_comb begin
      stk_req = '0;
      if (req_accept) begin
         if (req_n != 2'd0) begin
            stk_req = stack_access(req_item, 2'd0);
         end
      end else if (busy_ff && cnt_ff < work_n) begin
         stk_req = stack_access(work_ff, cnt_ff);
      end
   end

   xbeu_stack #(
      .STACK_WORDS(STACK_WORDS)
   ) u_stack (
      .clock   (clock),
      .stk_req (stk_req),
      .rdata   (stk_rdata)
   );

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (busy_ff && cnt_ff < work_n) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (fin_go) begin
         busy_in = 1'b0;
      end
      if (req_accept) begin
         busy_in = 1'b1;
         cnt_in  = (req_n != 2'd0) ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // read data of pop k is on stk_rdata while cnt_ff == k+1
   always_ff @(posedge clock) begin
      if (req_accept) begin
         work_ff <= req_item;
      end
      if (busy_ff && cnt_ff == 2'd1) begin
         pop0_ff <= stk_rdata;
      end
      if (busy_ff && cnt_ff == 2'd2) begin
         pop1_ff <= stk_rdata;
      end
   end

   // condition evaluation
   assign zf        = work_ff.cur_flags[FL_ZF];
   assign sf_eq_of  = work_ff.cur_flags[FL_SF] == work_ff.cur_flags[FL_OF];
   assign short_tgt = work_ff.cur_ip + {{8{work_ff.imm_word[7]}}, work_ff.imm_word[7:0]};
   assign cx_dec    = work_ff.cur_cx - 16'd1;
   assign sp_pop    = work_ff.cur_sp + 16'({work_n, 1'b0});

   // odd opcode inverts the condition
   always_comb begin
      case (cc_type'(work_ff.opcode[3:1]))
         CC_O:    jcc_take = work_ff.cur_flags[FL_OF] ^ work_ff.opcode[0];
         CC_B:    jcc_take = work_ff.cur_flags[FL_CF] ^ work_ff.opcode[0];
         CC_Z:    jcc_take = zf ^ work_ff.opcode[0];
         CC_BE:   jcc_take = (work_ff.cur_flags[FL_CF] | zf) ^ work_ff.opcode[0];
         CC_S:    jcc_take = work_ff.cur_flags[FL_SF] ^ work_ff.opcode[0];
         CC_P:    jcc_take = work_ff.cur_flags[FL_PF] ^ work_ff.opcode[0];
         CC_L:    jcc_take = sf_eq_of == work_ff.opcode[0];
         default: jcc_take = (!zf && sf_eq_of) == work_ff.opcode[0];
      endcase
   end

   always_comb begin
      res_ip     = work_ff.cur_ip;
      res_cs     = work_ff.cur_cs;
      res_sp     = work_ff.cur_sp;
      res_cx     = work_ff.cur_cx;
      res_flags  = work_ff.cur_flags;
      res_halt   = 1'b0;
      res_irq    = 1'b0;
      res_vec    = 8'd0;
      res_status = 1'b0;
      case (work_ff.opcode) inside
         [OP_JCC_FIRST:OP_JCC_LAST]: begin
            if (jcc_take) begin
               res_ip = short_tgt;
            end
         end
         OP_LOOPNZ, OP_LOOPZ: begin
            res_cx = cx_dec;
            if (cx_dec != 16'd0 && zf == work_ff.opcode[0]) begin
               res_ip = short_tgt;
            end
         end
         OP_LOOP: begin
            res_cx = cx_dec;
            if (cx_dec != 16'd0) begin
               res_ip = short_tgt;
            end
         end
         OP_JCXZ: begin
            if (work_ff.cur_cx == 16'd0) begin
               res_ip = short_tgt;
            end
         end
         OP_CALL_NEAR: begin
            res_sp = work_ff.cur_sp - 16'd2;
            res_ip = work_ff.cur_ip + work_ff.imm_word;
         end
         OP_JMP_NEAR: begin
            res_ip = work_ff.cur_ip + work_ff.imm_word;
         end
         OP_JMP_FAR: begin
            res_cs = work_ff.imm_segment;
            res_ip = work_ff.imm_word;
         end
         OP_JMP_SHORT: begin
            res_ip = short_tgt;
         end
         OP_CALL_FAR: begin
            res_sp = work_ff.cur_sp - 16'd4;
            res_cs = work_ff.imm_segment;
            res_ip = work_ff.imm_word;
         end
         OP_RET, OP_RET_IMM: begin
            res_ip = stk_rdata;
            res_sp = (work_ff.opcode == OP_RET_IMM) ? sp_pop + work_ff.imm_word : sp_pop;
         end
         OP_RETF, OP_RETF_IMM: begin
            res_ip = pop0_ff;
            res_cs = stk_rdata;
            res_sp = (work_ff.opcode == OP_RETF_IMM) ? sp_pop + work_ff.imm_word : sp_pop;
         end
         OP_INT3: begin
            res_irq = 1'b1;
            res_vec = VEC_BREAK;
         end
         OP_INT: begin
            res_irq = 1'b1;
            res_vec = work_ff.imm_word[7:0];
         end
         OP_INTO: begin
            if (work_ff.cur_flags[FL_OF]) begin
               res_irq = 1'b1;
               res_vec = VEC_OVERFLOW;
            end
         end
         OP_IRET: begin
            res_ip    = pop0_ff;
            res_cs    = pop1_ff;
            res_flags = stk_rdata;
            res_sp    = sp_pop;
         end
         OP_HLT: begin
            res_halt = 1'b1;
         end
         default: begin
            res_status = 1'b1;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (fin_go) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_tdata_ff <= {5'd0, res_status, res_vec, res_irq, res_halt,
                          res_flags, res_cx, res_sp, res_cs, res_ip};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `XB_ASSERT(a_cnt_bound, busy_ff |-> (cnt_ff <= work_n), "access count past opcode need")
   `XB_ASSERT(a_port_owner, stk_req.en |-> (req_accept || busy_ff), "stack access with no request")
   `XB_ASSERT(a_no_early_accept, (busy_ff && cnt_ff != work_n) |-> !req_tready, "accept during stack sequence")
   `XB_ASSERT(a_finish_shows, fin_go |=> rsp_tvalid_ff, "finished request not presented")
   `XB_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy_ff && !rsp_tvalid_ff), "not idle after reset")

endmodule

`default_nettype wire

// ===== src/xbeu_stack.sv =====
// ---------------------------------------------------------------------------
// xbeu_stack
// Word stack memory, single port, registered read, addressed by SP.
// ---------------------------------------------------------------------------
`default_nettype none

module xbeu_stack import xbeu_pkg::*; #(
   parameter int STACK_WORDS = XB_STACK_WORDS
) (
   input  logic        clock,
   input  stk_req_type stk_req,
   output logic [15:0] rdata
);

   localparam int AW    = $clog2(STACK_WORDS);
   localparam int STEPS = 16 - AW;
   localparam bit POW2  = (STACK_WORDS & (STACK_WORDS - 1)) == 0;

   logic [15:0]   mem [STACK_WORDS];
   logic [AW-1:0] slot;
   logic [15:0]   rdata_ff;

   // word index modulo STACK_WORDS; constant compare-subtract for sizes that are not a power of two
   function automatic logic [AW-1:0] slot_of(input logic [14:0] w);
      logic [15:0] v;
      int          i;
      v = {1'b0, w};
      for (i = STEPS - 1; i >= 0; i--) begin
         if (v >= 16'(STACK_WORDS << i)) begin
            v = v - 16'(STACK_WORDS << i);
         end
      end
      return POW2 ? w[AW-1:0] : v[AW-1:0];
   endfunction

   assign slot = slot_of(stk_req.sp[15:1]);

   always_ff @(posedge clock) begin
      if (stk_req.en) begin
         if (stk_req.we) begin
            mem[slot] <= stk_req.wdata;
         end else begin
            rdata_ff <= mem[slot];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
